// ===== hdl/sceb_pkg.sv =====
package sceb_pkg;

	// Instruction memory size in words, a power of two.
	localparam int IMEM_WORDS = 1024;
	localparam int IMEM_AW    = $clog2(IMEM_WORDS);

	// Address and bound widths follow the fixed field widths.
	localparam int START_W = 10;
	localparam int ADDR_W  = 11;

	localparam logic [START_W-1:0] START_MASK = START_W'(IMEM_WORDS - 1);
	localparam logic [ADDR_W-1:0]  IMEM_END   = ADDR_W'(IMEM_WORDS);

	// Opcode and function fields.
	localparam logic [6:0] VU_TAG     = 7'h25;
	localparam logic [5:0] OP_SPECIAL = 6'o00;
	localparam logic [5:0] OP_REGIMM  = 6'o01;
	localparam logic [5:0] OP_J       = 6'o02;
	localparam logic [5:0] OP_BEQ     = 6'o04;
	localparam logic [5:0] OP_BNE     = 6'o05;
	localparam logic [5:0] OP_BLEZ    = 6'o06;
	localparam logic [5:0] OP_BGTZ    = 6'o07;
	localparam logic [5:0] FN_JR      = 6'o10;
	localparam logic [5:0] FN_BREAK   = 6'o15;
	localparam logic [4:0] RT_BLTZ    = 5'o00;
	localparam logic [4:0] RT_BGEZ    = 5'o01;
	localparam logic [4:0] RT_BLTZAL  = 5'o20;
	localparam logic [4:0] RT_BGEZAL  = 5'o21;

	typedef struct packed {
		logic [31:0]        instr_word;
		logic [START_W-1:0] start_word;
		logic [ADDR_W-1:0]  end_word;
		logic               first;
	} item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] static_end;
		logic              finished;
	} result_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  reach;
		logic [ADDR_W-1:0]  addr;
		logic [START_W-1:0] region_start;
		logic [ADDR_W-1:0]  region_end;
		logic               done;
	} scan_state_t;

endpackage

// ===== hdl/sceb_step.sv =====
module sceb_step (
	input  sceb_pkg::scan_state_t state,
	input  sceb_pkg::item_t       item,
	output sceb_pkg::scan_state_t next_state,
	output sceb_pkg::result_t     result
);
	import sceb_pkg::*;

	scan_state_t       st;
	scan_state_t       nx;
	logic [5:0]        op;
	logic [ADDR_W-1:0] addr_p1;
	logic [ADDR_W-1:0] addr_p2;
	logic [ADDR_W-1:0] end_sat;
	logic [START_W-1:0] start_m;
	logic [IMEM_AW-1:0] br_tgt;
	logic [IMEM_AW-1:0] j_tgt;
	logic [ADDR_W-1:0] br_tgt_w;
	logic [ADDR_W-1:0] j_tgt_w;
	logic              covered;
	logic              br_in;
	logic              j_in;

	function automatic logic in_reg(input logic [ADDR_W-1:0] t,
		input logic [START_W-1:0] rs, input logic [ADDR_W-1:0] re);
		return (t >= ADDR_W'(rs)) && (t < re);
	endfunction

	function automatic logic [ADDR_W-1:0] umax(input logic [ADDR_W-1:0] a,
		input logic [ADDR_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	// A first item loads a fresh region before its word is decoded.
	always_comb begin
		start_m = item.start_word & START_MASK;
		end_sat = (item.end_word > IMEM_END) ? IMEM_END : item.end_word;
		st = state;
		if (item.first) begin
			st.region_start = start_m;
			st.region_end   = end_sat;
			st.reach        = ADDR_W'(start_m);
			st.addr         = ADDR_W'(start_m);
			st.done         = (end_sat <= ADDR_W'(start_m));
		end
	end

	assign op       = item.instr_word[31:26];
	assign addr_p1  = st.addr + ADDR_W'(1);
	assign addr_p2  = st.addr + ADDR_W'(2);
	assign covered  = !(addr_p1 >= st.reach);
	assign br_tgt   = IMEM_AW'(addr_p1) + item.instr_word[IMEM_AW-1:0];
	assign j_tgt    = item.instr_word[IMEM_AW-1:0];
	assign br_tgt_w = ADDR_W'(br_tgt);
	assign j_tgt_w  = ADDR_W'(j_tgt);
	assign br_in    = in_reg(br_tgt_w, st.region_start, st.region_end);
	assign j_in     = in_reg(j_tgt_w, st.region_start, st.region_end);

	always_comb begin
		nx = st;
		if (!st.done) begin
			if (!covered) begin
				nx.reach = addr_p1;
			end
			if (item.instr_word[31:25] != VU_TAG) begin
				case (op)
					OP_SPECIAL: begin
						if (!covered && item.instr_word[5:0] == FN_JR) begin
							nx.reach = umax(nx.reach, addr_p2);
							nx.done  = 1'b1;
						end else if (!covered && item.instr_word[5:0] == FN_BREAK) begin
							nx.done = 1'b1;
						end
					end
					OP_REGIMM: begin
						if (item.instr_word[20:16] inside {RT_BLTZ, RT_BGEZ, RT_BLTZAL,
							RT_BGEZAL} && br_in) begin
							nx.reach = umax(nx.reach, br_tgt_w + ADDR_W'(1));
						end
					end
					OP_J: begin
						if (!covered) begin
							nx.reach = umax(nx.reach, addr_p2);
							nx.done  = 1'b1;
						end else if (j_in) begin
							nx.reach = umax(nx.reach, j_tgt_w + ADDR_W'(1));
						end
					end
					OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
						if (br_in) begin
							nx.reach = umax(nx.reach, br_tgt_w + ADDR_W'(1));
						end
					end
					default: begin
					end
				endcase
			end
			nx.addr = addr_p1;
			if (addr_p1 >= st.region_end) begin
				nx.done = 1'b1;
			end
		end
	end

	assign next_state        = nx;
	assign result.static_end = (nx.reach < nx.region_end) ? nx.reach : nx.region_end;
	assign result.finished   = nx.done;

endmodule

// ===== hdl/static_code_block_end_scanner.sv =====
// Static code block end scanner.
// The item channel (item_valid, item_stall, item) carries one instruction
// word per transaction. A transaction with first set starts a new scan and
// also carries the start word address and the exclusive region end; each
// later transaction carries the word at the next address.
// The result channel (result_valid, result_stall, result) returns exactly one
// transaction per item: the running static end min(reach, region end) and a
// finished flag. Items that arrive after the scan has finished leave the
// state alone and repeat the last result.
// An item lands in the input register when it is accepted, and its result
// is then registered in the result register, where it can be taken. One item
// is accepted per cycle, sustained, while the receiver does not stall; the
// scan state update is a single combinational decode, add and compare.
// Reset empties both registers and leaves no scan active (static end zero,
// finished set); no result is offered until an item arrives.
// When the receiver stalls, the result register holds its transaction and
// one more item waits in the input register; item_stall rises only when
// both are full.
module static_code_block_end_scanner (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  sceb_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output sceb_pkg::result_t result
);
	import sceb_pkg::*;

	item_t       item_s1;
	logic        valid_s1;
	scan_state_t state_q;
	scan_state_t next_state;
	result_t     step_result;
	result_t     result_q;
	logic        result_valid_q;
	logic        adv;

	sceb_step u_step (
		.state      (state_q),
		.item       (item_s1),
		.next_state (next_state),
		.result     (step_result)
	);

	assign adv        = !result_valid_q || !result_stall;
	assign item_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1             <= 1'b0;
			result_valid_q       <= 1'b0;
			state_q.reach        <= '0;
			state_q.addr         <= '0;
			state_q.region_start <= '0;
			state_q.region_end   <= '0;
			state_q.done         <= 1'b1;
		end else begin
			if (!item_stall) begin
				valid_s1 <= item_valid;
			end
			if (adv) begin
				result_valid_q <= valid_s1;
				if (valid_s1) begin
					state_q <= next_state;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (adv && valid_s1) begin
			result_q <= step_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && result_valid_q))
		else $error("item stalled while a register was free");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !result_stall && !valid_s1) |=> !result_valid_q)
		else $error("result repeated after its transaction");

	a_active_in_region: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.done |-> (state_q.addr < state_q.region_end))
		else $error("active scan beyond region end");

	a_end_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.region_end <= IMEM_END)
		else $error("region end above memory size");
`endif

endmodule

// ===== sim/static_code_block_end_scanner_tb.sv =====
module static_code_block_end_scanner_tb;
	import sceb_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 600;

	// Tracks the scan the way the block should and holds the static ends
	// still owed by the block, oldest first.
	class static_end_tracker;
		logic [ADDR_W-1:0]  reach;
		logic [ADDR_W-1:0]  scan_index;
		logic [START_W-1:0] region_start;
		logic [ADDR_W-1:0]  region_end;
		bit                 done;
		result_t            pending_ends[$];
		int                 mismatches;
		int                 checked;

		function new();
			reach        = '0;
			scan_index   = '0;
			region_start = '0;
			region_end   = '0;
			done         = 1'b1;
			mismatches   = 0;
			checked      = 0;
		endfunction

		function int unsigned next_addr();
			return region_start + scan_index;
		endfunction

		function bit in_region(int unsigned t);
			return t >= region_start && t < region_end;
		endfunction

		function void raise_reach(int unsigned r);
			if (r > reach)
				reach = ADDR_W'(r);
		endfunction

		function void decode_word(logic [31:0] w);
			int unsigned a;
			int unsigned tgt;
			bit          covered;
			logic [4:0]  rt;
			a       = next_addr();
			tgt     = (a + 32'd1 + w) & (IMEM_WORDS - 1);
			rt      = w[20:16];
			covered = (a + 1 < reach);
			if (!covered)
				reach = ADDR_W'(a + 1);
			if (w[31:25] == VU_TAG)
				return;
			case (w[31:26])
				OP_SPECIAL: begin
					if (!covered && w[5:0] == FN_JR) begin
						raise_reach(a + 2);
						done = 1'b1;
					end else if (!covered && w[5:0] == FN_BREAK) begin
						done = 1'b1;
					end
				end
				OP_REGIMM: begin
					if ((rt == RT_BLTZ || rt == RT_BGEZ || rt == RT_BLTZAL || rt == RT_BGEZAL)
							&& in_region(tgt))
						raise_reach(tgt + 1);
				end
				OP_J: begin
					// An uncovered jump ends the block; a covered one never ends it and extends it only to a target in the region.
					if (!covered) begin
						raise_reach(a + 2);
						done = 1'b1;
					end else if (in_region(w & (IMEM_WORDS - 1))) begin
						raise_reach((w & (IMEM_WORDS - 1)) + 1);
					end
				end
				OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
					if (in_region(tgt))
						raise_reach(tgt + 1);
				end
				default: ;
			endcase
		endfunction

		function void note_item(item_t it);
			int unsigned lim;
			result_t     r;
			if (it.first) begin
				region_start = it.start_word & START_MASK;
				lim = it.end_word;
				if (lim > IMEM_WORDS)
					lim = IMEM_WORDS;
				region_end = ADDR_W'(lim);
				reach      = ADDR_W'(region_start);
				scan_index = '0;
				done       = (region_end <= region_start);
			end
			if (!done) begin
				decode_word(it.instr_word);
				scan_index++;
				if (next_addr() >= region_end)
					done = 1'b1;
			end
			r.static_end = (reach < region_end) ? reach : region_end;
			r.finished   = done;
			pending_ends = {pending_ends, r};
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_ends.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: static_end=%0d finished=%0b",
						got.static_end, got.finished);
				return;
			end
			want = pending_ends.pop_front();
			checked++;
			if (got.static_end !== want.static_end || got.finished !== want.finished) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result %0d: static_end exp %0d got %0d, finished exp %0b got %0b",
						checked, want.static_end, got.static_end, want.finished, got.finished);
			end
		endfunction
	endclass

	logic    clk;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	static_end_tracker tracker = new();
	bit calm   = 1'b0;
	int cycles = 0;

	static_code_block_end_scanner dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles.", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk)
		result_stall <= !calm && ($urandom_range(0, 99) < 18);

	// Values read right at the edge are the ones the edge sampled.
	always @(posedge clk)
		if (arst_n && result_valid && !result_stall)
			tracker.check_result(result);

	function automatic item_t word_item(logic [31:0] w);
		item_t it;
		it.instr_word = w;
		it.start_word = START_W'($urandom);
		it.end_word   = ADDR_W'($urandom);
		it.first      = 1'b0;
		return it;
	endfunction

	function automatic item_t scan_item(int unsigned s, int unsigned e, logic [31:0] w);
		item_t it;
		it.instr_word = w;
		it.start_word = START_W'(s);
		it.end_word   = ADDR_W'(e);
		it.first      = 1'b1;
		return it;
	endfunction

	function automatic logic [31:0] vu_word();
		logic [31:0] w;
		w = $urandom;
		w[31:25] = VU_TAG;
		return w;
	endfunction

	function automatic logic [31:0] special_word(logic [5:0] fn);
		logic [31:0] w;
		w = $urandom;
		w[31:26] = OP_SPECIAL;
		w[5:0]   = fn;
		return w;
	endfunction

	function automatic logic [31:0] jump_word(int unsigned tgt);
		logic [31:0] w;
		w = $urandom;
		w[31:26] = OP_J;
		w[IMEM_AW-1:0] = IMEM_AW'(tgt);
		return w;
	endfunction

	// Only the low address bits of the offset matter, since the target wraps.
	function automatic logic [31:0] branch_word(logic [5:0] op, logic [4:0] rt,
			int unsigned at, int unsigned tgt);
		logic [31:0] w;
		w = $urandom;
		w[31:26] = op;
		w[20:16] = rt;
		w[IMEM_AW-1:0] = IMEM_AW'(tgt - at - 1);
		return w;
	endfunction

	// Branch and jump targets are mostly short and forward, so later words are often covered.
	function automatic logic [31:0] random_word(int unsigned a);
		int unsigned tgt;
		int unsigned pick;
		logic [5:0]  op;
		logic [4:0]  rt;
		logic [5:0]  fn;
		if ($urandom_range(0, 3) == 0)
			tgt = $urandom_range(0, IMEM_WORDS - 1);
		else
			tgt = a + 1 + $urandom_range(0, 12);
		pick = $urandom_range(0, 99);
		if (pick < 25)
			return $urandom;
		if (pick < 35)
			return vu_word();
		if (pick < 60) begin
			case ($urandom_range(0, 3))
				0:       op = OP_BEQ;
				1:       op = OP_BNE;
				2:       op = OP_BLEZ;
				default: op = OP_BGTZ;
			endcase
			return branch_word(op, 5'($urandom), a, tgt);
		end
		if (pick < 72) begin
			case ($urandom_range(0, 4))
				0:       rt = RT_BLTZ;
				1:       rt = RT_BGEZ;
				2:       rt = RT_BLTZAL;
				3:       rt = RT_BGEZAL;
				default: rt = 5'($urandom);
			endcase
			return branch_word(OP_REGIMM, rt, a, tgt);
		end
		if (pick < 86) begin
			case ($urandom_range(0, 2))
				0:       fn = FN_JR;
				1:       fn = FN_BREAK;
				default: fn = 6'($urandom);
			endcase
			return special_word(fn);
		end
		return jump_word(tgt);
	endfunction

	task automatic send_item(input item_t it);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < 10)
			gap = $urandom_range(1, 3);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		tracker.note_item(it);
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending_ends.size() != 0);
	endtask

	initial begin
		int          counted;
		int          scans;
		int          ignored;
		int unsigned s;
		int unsigned e;
		int unsigned pick;
		counted = 0;
		scans   = 0;
		ignored = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Nothing is active after reset, so this word is ignored.
		send_item(word_item($urandom));
		// Empty regions.
		send_item(scan_item(100, 100, vu_word()));
		send_item(scan_item(0, 0, $urandom));
		// Region end above memory size, covered JR and BREAK, scan runs into the end.
		send_item(scan_item(1020, 2047, branch_word(OP_BEQ, 5'($urandom), 1020, 1023)));
		send_item(word_item(special_word(FN_JR)));
		send_item(word_item(special_word(FN_BREAK)));
		send_item(word_item(vu_word()));
		send_item(word_item($urandom));
		// Each REGIMM branch in and out of region, other REGIMM, J, BNE, BLEZ, BGTZ.
		send_item(scan_item(200, 260, branch_word(OP_REGIMM, RT_BLTZ, 200, 207)));
		send_item(word_item(branch_word(OP_REGIMM, RT_BGEZ, 201, 203)));
		send_item(word_item(branch_word(OP_REGIMM, RT_BLTZAL, 202, 300)));
		send_item(word_item(branch_word(OP_REGIMM, RT_BGEZAL, 203, 190)));
		send_item(word_item(branch_word(OP_REGIMM, 5'd2, 204, 230)));
		send_item(word_item(jump_word(210)));
		send_item(word_item(branch_word(OP_BNE, 5'($urandom), 206, 215)));
		send_item(word_item(branch_word(OP_BLEZ, 5'($urandom), 207, 100)));
		send_item(word_item(branch_word(OP_BGTZ, 5'($urandom), 208, 209)));
		send_item(word_item(special_word(6'o40)));
		// A new scan cuts the one above short; uncovered JR, J and BREAK end scans.
		send_item(scan_item(5, 50, special_word(FN_JR)));
		send_item(scan_item(7, 30, jump_word(20)));
		send_item(scan_item(40, 60, special_word(FN_BREAK)));
		// Top word of memory with a branch target that wraps past zero.
		send_item(scan_item(1023, 1024, branch_word(OP_BEQ, 5'($urandom), 1023, 1)));
		send_item(scan_item(300, 310, branch_word(OP_BEQ, 5'($urandom), 300, 305)));
		send_item(word_item(jump_word(309)));
		drain_results();

		while (counted < RANDOM_ITEMS) begin
			calm = (counted >= 150 && counted < 300);
			if (counted == 400)
				drain_results();
			if (tracker.done || $urandom_range(0, 99) < 3) begin
				if (tracker.done && $urandom_range(0, 2) == 0)
					repeat ($urandom_range(1, 3)) begin
						send_item(word_item($urandom));
						ignored++;
					end
				pick = $urandom_range(0, 99);
				s = $urandom_range(0, IMEM_WORDS - 1);
				if (pick < 6) begin
					e = $urandom_range(0, s);
				end else if (pick < 12) begin
					s = $urandom_range(IMEM_WORDS - 30, IMEM_WORDS - 1);
					e = $urandom_range(IMEM_WORDS + 1, 2047);
				end else begin
					e = s + $urandom_range(1, 40);
					if (e > IMEM_WORDS)
						e = IMEM_WORDS;
				end
				send_item(scan_item(s, e, random_word(s)));
				scans++;
			end else begin
				send_item(word_item(random_word(tracker.next_addr())));
			end
			counted++;
		end
		calm = 1'b0;

		drain_results();
		repeat (10) @(posedge clk);
		$display("Random part: %0d scans over %0d decoded items, %0d items after a scan ended.",
			scans, counted, ignored);
		$display("%0d results checked, %0d mismatches.", tracker.checked, tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.pending_ends.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
